/* hw/rtl/two_point_pointer_calibration_defines.svh */
// Assertion macros shared by the pointer calibration RTL.
`ifndef TWO_POINT_POINTER_CALIBRATION_DEFINES_SVH
`define TWO_POINT_POINTER_CALIBRATION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TPPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define TPPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tppc_pkg.sv */
// Types, constants and helpers shared by the pointer calibration modules.
package tppc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int RAW_W     = 16;
    localparam int SIZE_W    = 12;
    localparam int NUM_W     = 11;
    localparam int DEN_W     = RAW_W + 1;
    localparam int QUO_W     = NUM_W + FRAC_BITS;
    localparam int GAIN_W    = 32;
    localparam int OFS_W     = 48;
    localparam int SUM_W     = OFS_W + 1;
    localparam int CUR_W     = 16;
    localparam int QCNT_W    = $clog2(QUO_W);
    localparam int MCNT_W    = $clog2(RAW_W);
    localparam int ADDR_W    = 3;
    localparam int APB_W     = 32;
    localparam int M_DATA_W  = 2 * CUR_W + 2 * SIZE_W;

    // size*61/160 as a multiply by a scaled reciprocal, exact for 12-bit sizes
    localparam int TGT_MUL_W = 19;
    localparam int TGT_MUL   = 399770;
    localparam int TGT_SHIFT = 20;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(320);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(240);

    // register index codes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [RAW_W-1:0]  t_raw;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [DEN_W-1:0]  t_den;
    typedef logic [QUO_W-1:0]  t_quo;
    typedef logic [GAIN_W-1:0] t_gain;
    typedef logic [OFS_W-1:0]  t_ofs;

    // Start and finish strobes of a serial arithmetic unit.
    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic done;
    } t_unit_sts;

    // Distance between the two targets on one axis: floor(size*61/160).
    function automatic t_num tgt_delta(input t_size size);
        logic [SIZE_W+TGT_MUL_W-1:0] p;
        p = (SIZE_W+TGT_MUL_W)'(size) * (SIZE_W+TGT_MUL_W)'(TGT_MUL);
        return p[TGT_SHIFT +: NUM_W];
    endfunction

endpackage

/* hw/rtl/tppc_div.sv */
// Radix-2 restoring divider: one quotient bit per cycle.
module tppc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tppc_pkg::t_unit_ctl i_ctl,
    input  tppc_pkg::t_num    i_num,
    input  tppc_pkg::t_den    i_dvs,
    output tppc_pkg::t_unit_sts o_sts,
    output tppc_pkg::t_quo    o_quo
);
    import tppc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_dvs;
    logic [QUO_W-1:0]  r_quo;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_fit;
    logic [DEN_W-1:0]  n_rem;

    // shift the next dividend bit into the partial remainder and try the divisor
    always_comb begin
        w_trial = {r_rem, r_quo[QUO_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_fit   = w_trial >= {1'b0, r_dvs};
        n_rem   = w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + QCNT_W'(1);
                if (r_cnt == QCNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend and quotient share one shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= {i_num, FRAC_BITS'(0)};
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_quo <= {r_quo[QUO_W-2:0], w_fit};
            r_rem <= n_rem;
        end
    end

    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

/* hw/rtl/tppc_mul.sv */
// Bit-serial signed multiplier: gain times a 16-bit reading, MSB first.
module tppc_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tppc_pkg::t_unit_ctl i_ctl,
    input  tppc_pkg::t_gain   i_a,
    input  tppc_pkg::t_raw    i_b,
    output tppc_pkg::t_unit_sts o_sts,
    output tppc_pkg::t_ofs    o_prod
);
    import tppc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [MCNT_W-1:0] r_cnt;
    logic [GAIN_W-1:0] r_a;
    logic [RAW_W-1:0]  r_b;
    logic [OFS_W-1:0]  r_acc;

    logic [OFS_W-1:0]  w_part;
    logic [OFS_W-1:0]  n_acc;

    // the sign bit of the reading carries negative weight
    always_comb begin
        w_part = r_b[RAW_W-1] ? {{(OFS_W-GAIN_W){r_a[GAIN_W-1]}}, r_a} : '0;
        if (r_cnt == '0) begin
            n_acc = '0 - w_part;
        end else begin
            n_acc = {r_acc[OFS_W-2:0], 1'b0} + w_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MCNT_W'(1);
                if (r_cnt == MCNT_W'(RAW_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            r_b   <= {r_b[RAW_W-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

/* hw/rtl/two_point_pointer_calibration.sv */
// Top level of the two-point pointer calibration block.
//
// Usage
//   Input beats arrive on s_axis: tdata carries raw_x and raw_y, tuser the
//   capture flag. Each accepted beat yields exactly one result beat on
//   m_axis: the calibrated cursor, the phase after the beat and the screen
//   position of the target to aim at next. The screen width and height
//   registers sit on the APB port at byte addresses 0 and 4; write them
//   only while the block is idle.
// Sequencing
//   One beat is worked on at a time. An ordinary beat runs the start of a
//   serial multiply, the multiply, the sum and the output load; the next beat
//   is taken once the block is back in idle. A capture that completes
//   calibration first runs the divide and a serial multiply for the offsets.
// Reset and stalls
//   Reset clears phase, captures, gains and offsets, so the cursor reads
//   (0,0) until calibrated, and loads the 320 x 240 screen size. A result
//   held in the output register waits for m_axis_tready; the next beat is
//   still accepted and worked on, and stalls only when it must deliver.
module two_point_pointer_calibration (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side: [15:0] raw_x, [31:16] raw_y
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,
    // slave side user: [0] capture
    input  logic                          s_axis_tuser,
    // master side: [15:0] cursor_x, [31:16] cursor_y, [43:32] target_x,
    // [55:44] target_y
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tppc_pkg::M_DATA_W-1:0] m_axis_tdata,
    // master side user: [0] target_index
    output logic                          m_axis_tuser,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tppc_pkg::ADDR_W-1:0]   paddr,
    input  logic [tppc_pkg::APB_W-1:0]    pwdata,
    output logic [tppc_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import tppc_pkg::*;

`include "two_point_pointer_calibration_defines.svh"

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_OFS  = 5'b00100,
        S_MAP  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic            r_go, n_go;

    // configuration and the target spacing derived from it
    t_size           r_width, r_height;
    t_num            r_num_x, r_num_y;

    // calibration state
    logic            r_phase;
    t_raw            r_cap0_x, r_cap0_y;
    t_gain           r_gain_x, r_gain_y;
    t_ofs            r_ofs_x, r_ofs_y;

    // beat in flight
    t_raw            r_raw_x, r_raw_y;
    t_den            r_mag_x, r_mag_y;
    logic            r_neg_x, r_neg_y;
    logic            r_zero_x, r_zero_y;
    logic [SUM_W-1:0] r_sum_x, r_sum_y;

    // output register
    logic            r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic            r_m_user;

    logic            w_s_acc;
    logic            w_cfg_wr;
    logic            w_out_load;
    t_raw            w_in_x, w_in_y;
    t_den            w_den_x, w_den_y;
    t_unit_ctl       w_div_ctl, w_mul_ctl;
    t_unit_sts       w_div_sts_x, w_div_sts_y, w_mul_sts_x, w_mul_sts_y;
    t_quo            w_quo_x, w_quo_y;
    t_ofs            w_prod_x, w_prod_y;
    t_raw            w_mul_b_x, w_mul_b_y;
    t_size           w_t0_x, w_t0_y, w_tgt_x, w_tgt_y;
    logic [CUR_W-1:0] w_cur_x, w_cur_y;

    // Saturate the unsigned quotient into a signed gain; hold the old gain
    // when the raw delta is zero.
    function automatic t_gain gain_sat(input t_gain old, input t_quo quo,
                                       input logic zero, input logic neg);
        logic [63:0] qe;
        t_gain       mag;
        qe = 64'(quo);
        if (zero) begin
            return old;
        end else if (!neg) begin
            return (qe > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qe[GAIN_W-1:0];
        end else begin
            mag = (qe > 64'h8000_0000) ? 32'h8000_0000 : qe[GAIN_W-1:0];
            return '0 - mag;
        end
    endfunction

    // Drop the fraction toward zero, then clamp to 16 signed bits.
    function automatic logic [CUR_W-1:0] to_cursor(input logic [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] s;
        logic [SUM_W-1:0]        t;
        logic                    fits;
        s    = $signed(v) >>> FRAC_BITS;
        t    = s + SUM_W'(v[SUM_W-1] & (|v[FRAC_BITS-1:0]));
        fits = (&t[SUM_W-1:CUR_W-1]) | ~(|t[SUM_W-1:CUR_W-1]);
        if (fits) begin
            return t[CUR_W-1:0];
        end else begin
            return t[SUM_W-1] ? {1'b1, {(CUR_W-1){1'b0}}} : {1'b0, {(CUR_W-1){1'b1}}};
        end
    endfunction

    assign w_in_x  = s_axis_tdata[RAW_W-1:0];
    assign w_in_y  = s_axis_tdata[2*RAW_W-1:RAW_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc = s_axis_tvalid && s_axis_tready;

    // raw delta of the two captures; the second capture is the beat itself
    assign w_den_x = {r_cap0_x[RAW_W-1], r_cap0_x} - {w_in_x[RAW_W-1], w_in_x};
    assign w_den_y = {r_cap0_y[RAW_W-1], r_cap0_y} - {w_in_y[RAW_W-1], w_in_y};

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[ADDR_W-1] == REG_HEIGHT) ? APB_W'(r_height) : APB_W'(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (w_cfg_wr) begin
            if (paddr[ADDR_W-1] == REG_WIDTH) begin
                r_width <= pwdata[SIZE_W-1:0];
            end else begin
                r_height <= pwdata[SIZE_W-1:0];
            end
        end
    end

    // target spacing follows the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_num_x <= tgt_delta(r_width);
        r_num_y <= tgt_delta(r_height);
    end

    assign w_t0_x = {1'b0, r_width[SIZE_W-1:1]};
    assign w_t0_y = {1'b0, r_height[SIZE_W-1:1]};

    // ---------------------------------------------------------------------
    // Sequencer: IDLE -> [DIV -> OFS ->] MAP -> OUT -> IDLE
    // ---------------------------------------------------------------------
    assign w_out_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_go    = 1'b1;
                    n_state = (s_axis_tuser && r_phase) ? S_DIV : S_MAP;
                end
            end
            S_DIV: begin
                if (w_div_sts_x.done) begin
                    n_go    = 1'b1;
                    n_state = S_OFS;
                end
            end
            S_OFS: begin
                if (w_mul_sts_x.done) begin
                    n_go    = 1'b1;
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                if (w_mul_sts_x.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

    // ---------------------------------------------------------------------
    // Calibration state
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 1'b0;
            r_cap0_x <= '0;
            r_cap0_y <= '0;
            r_gain_x <= '0;
            r_gain_y <= '0;
            r_ofs_x  <= '0;
            r_ofs_y  <= '0;
        end else begin
            if (w_s_acc && s_axis_tuser) begin
                r_phase <= ~r_phase;
                if (!r_phase) begin
                    r_cap0_x <= w_in_x;
                    r_cap0_y <= w_in_y;
                end
            end
            if ((r_state == S_DIV) && w_div_sts_x.done) begin
                r_gain_x <= gain_sat(r_gain_x, w_quo_x, r_zero_x, r_neg_x);
                r_gain_y <= gain_sat(r_gain_y, w_quo_y, r_zero_y, r_neg_y);
            end
            // offset = target0 - gain*raw0, both with the fraction bits
            if ((r_state == S_OFS) && w_mul_sts_x.done) begin
                r_ofs_x <= (OFS_W'(w_t0_x) << FRAC_BITS) - w_prod_x;
                r_ofs_y <= (OFS_W'(w_t0_y) << FRAC_BITS) - w_prod_y;
            end
        end
    end

    // beat payload and divider operands
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_raw_x  <= w_in_x;
            r_raw_y  <= w_in_y;
            r_neg_x  <= w_den_x[DEN_W-1];
            r_neg_y  <= w_den_y[DEN_W-1];
            r_zero_x <= (w_den_x == '0);
            r_zero_y <= (w_den_y == '0);
            r_mag_x  <= w_den_x[DEN_W-1] ? ('0 - w_den_x) : w_den_x;
            r_mag_y  <= w_den_y[DEN_W-1] ? ('0 - w_den_y) : w_den_y;
        end
        if ((r_state == S_MAP) && w_mul_sts_x.done) begin
            r_sum_x <= {r_ofs_x[OFS_W-1], r_ofs_x} + {w_prod_x[OFS_W-1], w_prod_x};
            r_sum_y <= {r_ofs_y[OFS_W-1], r_ofs_y} + {w_prod_y[OFS_W-1], w_prod_y};
        end
    end

    // ---------------------------------------------------------------------
    // Serial arithmetic, one lane per axis
    // ---------------------------------------------------------------------
    assign w_div_ctl.start = r_go && (r_state == S_DIV);
    assign w_mul_ctl.start = r_go && ((r_state == S_OFS) || (r_state == S_MAP));
    assign w_mul_b_x = (r_state == S_OFS) ? r_cap0_x : r_raw_x;
    assign w_mul_b_y = (r_state == S_OFS) ? r_cap0_y : r_raw_y;

    tppc_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_num_x),
        .i_dvs   (r_mag_x),
        .o_sts   (w_div_sts_x),
        .o_quo   (w_quo_x)
    );

    tppc_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_num_y),
        .i_dvs   (r_mag_y),
        .o_sts   (w_div_sts_y),
        .o_quo   (w_quo_y)
    );

    tppc_mul u_mul_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mul_ctl),
        .i_a     (r_gain_x),
        .i_b     (w_mul_b_x),
        .o_sts   (w_mul_sts_x),
        .o_prod  (w_prod_x)
    );

    tppc_mul u_mul_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mul_ctl),
        .i_a     (r_gain_y),
        .i_b     (w_mul_b_y),
        .o_sts   (w_mul_sts_y),
        .o_prod  (w_prod_y)
    );

    // ---------------------------------------------------------------------
    // Output register: hold the result until the receiver takes it
    // ---------------------------------------------------------------------
    assign w_cur_x = to_cursor(r_sum_x);
    assign w_cur_y = to_cursor(r_sum_y);
    assign w_tgt_x = r_phase ? (w_t0_x - SIZE_W'(r_num_x)) : w_t0_x;
    assign w_tgt_y = r_phase ? (w_t0_y - SIZE_W'(r_num_y)) : w_t0_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {w_tgt_y, w_tgt_x, w_cur_y, w_cur_x};
            r_m_user <= r_phase;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    `TPPC_ASSERT_IMP(a_div_done_in_div, w_div_sts_x.done, r_state == S_DIV, "divider finished outside DIV")
    `TPPC_ASSERT_IMP(a_div_lanes, w_div_sts_x.done != w_div_sts_y.done, 1'b0, "divide lanes apart")
    `TPPC_ASSERT_IMP(a_lanes_in_step, w_mul_sts_x.done != w_mul_sts_y.done, 1'b0, "multiplier lanes out of step")
    `TPPC_ASSERT_IMP(a_phase_on_capture, r_phase != $past(r_phase), $past(w_s_acc && s_axis_tuser), "phase moved without a capture")
    `TPPC_ASSERT_IMP(a_out_from_seq, $rose(r_m_valid), $past(r_state == S_OUT), "result loaded outside OUT")
    `TPPC_ASSERT_NXT(a_busy_after_accept, w_s_acc, !s_axis_tready, "accepted a second beat while busy")

endmodule
